// ===== design/nsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsm_pkg
// Shared types and constants of the NFA string matcher: field widths,
// operation codes, controller states, command/status groups, table entry.
// ----------------------------------------------------------------------------
package nsm_pkg;

  localparam int NSM_NUM_STATES    = 16;
  localparam int NSM_MAX_RELATIONS = 8;

  localparam int SYM_W   = 8;
  localparam int STF_W   = 4;  // from_state / to_state field width
  localparam int SLOT_W  = 3;
  localparam int CFG_W   = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } nsm_state_t;

  typedef struct packed {
    logic clear_write;
    logic table_write;
    logic start_char;
    logic scan_issue;
    logic finish;
  } nsm_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic out_free;
  } nsm_stat_t;

  typedef struct packed {
    logic             vld;
    logic [STF_W-1:0] tgt;
    logic [SYM_W-1:0] sym;
  } nsm_entry_t;

endpackage

`default_nettype wire

// ===== design/nsm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsm_if
// Handshake channels of the NFA string matcher: input items, result items
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface nsm_in_if
  import nsm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SYM_W-1:0]  symbol;
  logic [STF_W-1:0]  from_state;
  logic [SLOT_W-1:0] slot;
  logic [STF_W-1:0]  to_state;
  logic              enable;
  logic              last;

  modport source (output valid, operation, symbol, from_state, slot, to_state,
                  enable, last, input ready);
  modport sink   (input valid, operation, symbol, from_state, slot, to_state,
                  enable, last, output ready);
endinterface

interface nsm_out_if ();
  logic valid;
  logic ready;
  logic accepted;
  logic alive;
  logic last_res;

  modport source (output valid, accepted, alive, last_res, input ready);
  modport sink   (input valid, accepted, alive, last_res, output ready);
endinterface

interface nsm_cfg_if
  import nsm_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== design/nsm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsm_ctrl
// Controller: clearing pass after reset, table writes, and the per-character
// scan of the transition memory.
// ----------------------------------------------------------------------------
module nsm_ctrl
  import nsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_op,
  output logic           in_ready,
  input  wire nsm_stat_t stat,
  output nsm_cmd_t       cmd
);

  nsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.last_addr) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_CHAR) begin
            cmd.start_char = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.table_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.last_addr) state_nxt = ST_DRAIN;
      end
      // last read data is evaluated here
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/nsm_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nsm_dpath
// Datapath: transition memory, scan counters, active-set registers, match
// logic, configuration register and the result output register.
// ----------------------------------------------------------------------------
module nsm_dpath
  import nsm_pkg::*;
#(
  parameter int NUM_STATES    = NSM_NUM_STATES,
  parameter int MAX_RELATIONS = NSM_MAX_RELATIONS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nsm_cmd_t          cmd,
  output nsm_stat_t              stat,
  input  wire logic [SYM_W-1:0]  in_symbol,
  input  wire logic [STF_W-1:0]  in_from_state,
  input  wire logic [SLOT_W-1:0] in_slot,
  input  wire logic [STF_W-1:0]  in_to_state,
  input  wire logic              in_enable,
  input  wire logic              in_last,
  input  wire logic              cfg_wr,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_accepted,
  output logic                   out_alive,
  output logic                   out_last_res
);

  localparam int TABLE_SIZE = NUM_STATES * MAX_RELATIONS;
  localparam int SW = $clog2(NUM_STATES);
  localparam int RW = (MAX_RELATIONS > 1) ? $clog2(MAX_RELATIONS) : 1;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int NW = $clog2(NUM_STATES + 1);
  localparam int MW = (NW > CFG_W) ? NW : CFG_W;
  localparam int CW = (NW > STF_W) ? NW : STF_W;
  localparam int FW = (NW > STF_W + 1) ? NW : STF_W + 1;
  localparam int XW = (RW > SLOT_W + 1) ? RW : SLOT_W + 1;

  // ---------------- configuration register
  logic [CFG_W-1:0] state_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= CFG_W'(1);
    end else if (cfg_wr) begin
      state_count_r <= cfg_data;
    end
  end

  // saturate the state count into 1..NUM_STATES
  logic [MW-1:0] sc_ext;
  logic [NW-1:0] n_cfg;
  logic [NUM_STATES-1:0] mask_cfg;

  always_comb begin
    sc_ext = MW'(state_count_r);
    if (sc_ext == '0) begin
      n_cfg = NW'(1);
    end else if (sc_ext > MW'(NUM_STATES)) begin
      n_cfg = NW'(NUM_STATES);
    end else begin
      n_cfg = NW'(sc_ext);
    end
    for (int i = 0; i < NUM_STATES; i++) begin
      mask_cfg[i] = (MW'(i) < MW'(n_cfg));
    end
  end

  // ---------------- scan counters
  logic [AW-1:0] cnt_addr_r, cnt_addr_nxt;
  logic [SW-1:0] cnt_state_r, cnt_state_nxt;
  logic [RW-1:0] cnt_rel_r, cnt_rel_nxt;

  always_comb begin
    cnt_addr_nxt  = cnt_addr_r;
    cnt_state_nxt = cnt_state_r;
    cnt_rel_nxt   = cnt_rel_r;
    if (cmd.start_char) begin
      cnt_addr_nxt  = '0;
      cnt_state_nxt = '0;
      cnt_rel_nxt   = '0;
    end else if (cmd.scan_issue || cmd.clear_write) begin
      cnt_addr_nxt = cnt_addr_r + AW'(1);
      if (cnt_rel_r == RW'(MAX_RELATIONS - 1)) begin
        cnt_rel_nxt   = '0;
        cnt_state_nxt = cnt_state_r + SW'(1);
      end else begin
        cnt_rel_nxt = cnt_rel_r + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_addr_r  <= '0;
      cnt_state_r <= '0;
      cnt_rel_r   <= '0;
    end else begin
      cnt_addr_r  <= cnt_addr_nxt;
      cnt_state_r <= cnt_state_nxt;
      cnt_rel_r   <= cnt_rel_nxt;
    end
  end

  assign stat.last_addr = (cnt_addr_r == AW'(TABLE_SIZE - 1));

  // ---------------- transition memory
  nsm_entry_t mem [TABLE_SIZE];
  nsm_entry_t rd_data_r;
  nsm_entry_t wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic          wr_in_range;

  always_comb begin
    wr_in_range = (FW'(in_from_state) < FW'(NUM_STATES)) &&
                  (XW'(in_slot) < XW'(MAX_RELATIONS));
    if (cmd.clear_write) begin
      wr_en   = 1'b1;
      wr_addr = cnt_addr_r;
      wr_data = '0;
    end else begin
      wr_en   = cmd.table_write && wr_in_range;
      wr_addr = AW'(AW'(in_from_state) * AW'(MAX_RELATIONS) + AW'(in_slot));
      wr_data = '{vld: in_enable, tgt: in_to_state, sym: in_symbol};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[cnt_addr_r];
  end

  // state owning the entry whose data is held in rd_data_r
  logic          pipe_vld_r;
  logic [SW-1:0] pipe_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r <= 1'b0;
    end else begin
      pipe_vld_r <= cmd.scan_issue;
    end
    pipe_state_r <= cnt_state_r;
  end

  // ---------------- active set and match
  logic [NUM_STATES-1:0] active_r, active_nxt;
  logic [NUM_STATES-1:0] cur_r, cur_nxt;
  logic [NUM_STATES-1:0] next_r, next_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [SYM_W-1:0]      sym_r;
  logic                  last_r;
  logic                  hit;
  logic [NUM_STATES-1:0] mask_run;
  logic                  res_accepted;
  logic                  res_alive;

  always_comb begin
    hit = pipe_vld_r && cur_r[pipe_state_r] && rd_data_r.vld && (rd_data_r.sym == sym_r);
    for (int i = 0; i < NUM_STATES; i++) begin
      mask_run[i] = (NW'(i) < n_r);
    end
    cur_nxt    = cur_r;
    n_nxt      = n_r;
    next_nxt   = next_r;
    active_nxt = active_r;
    if (cmd.start_char) begin
      cur_nxt  = active_r & mask_cfg;
      n_nxt    = n_cfg;
      next_nxt = '0;
    end else begin
      for (int i = 0; i < NUM_STATES; i++) begin
        // drop targets at or above the state count
        if (hit && (CW'(rd_data_r.tgt) == CW'(i)) && (CW'(i) < CW'(n_r))) begin
          next_nxt[i] = 1'b1;
        end
      end
    end
    if (cmd.finish) begin
      active_nxt = last_r ? NUM_STATES'(1) : next_r;
    end
    res_accepted = next_r[SW'(n_r - NW'(1))];
    res_alive    = |next_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= NUM_STATES'(1);
      cur_r    <= '0;
      next_r   <= '0;
      n_r      <= NW'(1);
    end else begin
      active_r <= active_nxt;
      cur_r    <= cur_nxt;
      next_r   <= next_nxt;
      n_r      <= n_nxt;
    end
    if (cmd.start_char) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
  end

  // ---------------- output register
  logic out_valid_r;
  logic out_accepted_r;
  logic out_alive_r;
  logic out_last_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      out_accepted_r <= res_accepted;
      out_alive_r    <= res_alive;
      out_last_res_r <= last_r;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_alive      = out_alive_r;
  assign out_last_res   = out_last_res_r;

  // ---------------- assertions
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result appeared without a finish command");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("finish overwrote an untaken result");

  a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && last_r) |=> (active_r == NUM_STATES'(1)))
    else $error("active set not restarted after last character");

  a_next_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r & ~mask_run) == '0)
    else $error("next set holds a state beyond the count");

endmodule

`default_nettype wire

// ===== design/nfa_string_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nfa_string_matcher
// NFA simulation over a character stream with a writable transition table.
// ----------------------------------------------------------------------------
// A table write item is taken in the idle state and yields no result. For a
// character item the transition memory, which has a single read port, is
// scanned: every entry is read and matched once per character, followed by
// the read data register, an evaluation state and the finish state, which
// waits for a free output register. One result item per character is held
// in an output register, so the next item is taken while it waits. After
// reset a clearing pass over every table entry invalidates the table; no
// item is accepted during it, configuration writes are. The user must write
// configuration (state_count) only while idle; not enforced by the block.
module nfa_string_matcher
  import nsm_pkg::*;
#(
  parameter int NUM_STATES    = NSM_NUM_STATES,
  parameter int MAX_RELATIONS = NSM_MAX_RELATIONS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nsm_in_if.sink    in_if,
  nsm_out_if.source out_if,
  nsm_cfg_if.sink   cfg_if
);

  nsm_cmd_t  cmd;
  nsm_stat_t stat;
  logic      in_ready;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;

  nsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_if.operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsm_dpath #(
    .NUM_STATES    (NUM_STATES),
    .MAX_RELATIONS (MAX_RELATIONS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_symbol     (in_if.symbol),
    .in_from_state (in_if.from_state),
    .in_slot       (in_if.slot),
    .in_to_state   (in_if.to_state),
    .in_enable     (in_if.enable),
    .in_last       (in_if.last),
    .cfg_wr        (cfg_if.valid),
    .cfg_data      (cfg_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_accepted  (out_if.accepted),
    .out_alive     (out_if.alive),
    .out_last_res  (out_if.last_res)
  );

endmodule

`default_nettype wire
